@@ rtl/core/rmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, widths and helpers for the rotation-matrix-to-quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Port field width and internal term widths
    localparam int DATA_W        = 16;
    localparam int TERM_W        = 17;  // sum or difference of two elements
    localparam int CAND_W        = 18;  // sum or difference of three elements
    localparam int BEST_W        = 17;  // magnitude bits of the non-negative winner
    localparam int QUOT_W        = 16;  // scaled term magnitude never exceeds 32768
    localparam int FRAC_BITS_DEF = 14;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Radicand width: (best + ONE) << (FRAC_BITS - 2)
    function automatic int rad_w(input int fb);
        return imax(BEST_W, fb) + 1 + fb - 2;
    endfunction

    localparam int RAD_W_DEF  = rad_w(FRAC_BITS_DEF);
    localparam int ROOT_W_DEF = (RAD_W_DEF + 1) / 2 + 1;

    // Which component comes from the square root
    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z,
        SEL_W
    } rmq_sel_t;

    // Sideband riding alongside the root: winner and the three raw terms
    typedef struct packed {
        rmq_sel_t                  sel;
        logic [2:0][TERM_W-1:0]    lane;
    } rmq_side_t;

    // Divider result: magnitudes plus their signs
    typedef struct packed {
        rmq_sel_t                  sel;
        logic [2:0]                neg;
        logic [2:0][QUOT_W-1:0]    quot;
    } rmq_quot_t;

endpackage

@@ rtl/core/rmq_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage, rounded to
// nearest in a final stage. Sideband travels with each request.
// ----------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int RAD_W = RAD_W_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [RAD_W-1:0]       in_rad,
    input  rmq_side_t              in_side,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [(RAD_W+1)/2:0]   out_root,
    output rmq_side_t              out_side
);

    localparam int R_W    = (RAD_W + 1) / 2;
    localparam int LAST   = R_W;
    localparam int ROOT_W = R_W + 1;

    logic               valid_reg [0:LAST];
    logic [RAD_W-1:0]   rem_reg   [0:LAST];
    logic [RAD_W:0]     root_reg  [0:LAST];
    rmq_side_t          side_reg  [0:LAST];
    logic               rdy       [0:LAST];

    for (genvar k = 0; k <= LAST; k++) begin : g_stage
        logic             p_valid;
        logic [RAD_W-1:0] p_rem;
        logic [RAD_W:0]   p_root;
        rmq_side_t        p_side;
        logic [RAD_W-1:0] rem_next;
        logic [RAD_W:0]   root_next;

        // Previous stage or the input port
        if (k == 0) begin : g_src_in
            assign p_valid = in_valid;
            assign p_rem   = in_rad;
            assign p_root  = '0;
            assign p_side  = in_side;
        end
        else begin : g_src_prev
            assign p_valid = valid_reg[k-1];
            assign p_rem   = rem_reg[k-1];
            assign p_root  = root_reg[k-1];
            assign p_side  = side_reg[k-1];
        end

        if (k < LAST) begin : g_step
            localparam int SH = 2 * (R_W - 1 - k);
            logic [RAD_W:0] bitv;
            logic [RAD_W:0] trial;
            logic           fits;

            // Try the next root bit against the remainder
            always_comb
            begin
                bitv  = (RAD_W + 1)'(1) << SH;
                trial = p_root + bitv;
                fits  = ({1'b0, p_rem} >= trial);
                if (fits)
                begin
                    rem_next  = p_rem - trial[RAD_W-1:0];
                    root_next = (p_root >> 1) + bitv;
                end
                else
                begin
                    rem_next  = p_rem;
                    root_next = p_root >> 1;
                end
            end
        end
        else begin : g_round
            // Round to nearest: step up when remainder exceeds the root
            always_comb
            begin
                rem_next = p_rem;
                if ({1'b0, p_rem} > p_root)
                    root_next = p_root + (RAD_W + 1)'(1);
                else
                    root_next = p_root;
            end
        end

        // Stage moves when empty or when the next stage takes its request
        if (k == LAST) begin : g_rdy_last
            assign rdy[k] = !valid_reg[k] || out_ready;
        end
        else begin : g_rdy_mid
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (rdy[k])
                valid_reg[k] <= p_valid;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && p_valid)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= p_side;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[LAST];
    assign out_root  = root_reg[LAST][ROOT_W-1:0];
    assign out_side  = side_reg[LAST];

endmodule

@@ rtl/core/rmq_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider: each lane forms
// round(|D| * 2^FRAC_BITS / (4 V)), one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ROOT_W    = ROOT_W_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ROOT_W-1:0]   in_root,
    input  rmq_side_t           in_side,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ROOT_W-1:0]   out_root,
    output rmq_quot_t           out_quot
);

    localparam int NUM_W = imax(TERM_W + FRAC_BITS, ROOT_W + 1) + 1;
    localparam int DW    = imax(NUM_W, ROOT_W + 2 + QUOT_W - 1);
    localparam int LAST  = QUOT_W;

    logic               valid_reg [0:LAST];
    logic [DW-1:0]      rem_reg   [0:LAST][3];
    logic [QUOT_W-1:0]  quot_reg  [0:LAST][3];
    logic [2:0]         neg_reg   [0:LAST];
    logic [DW-1:0]      den_reg   [0:LAST];
    logic [ROOT_W-1:0]  root_reg  [0:LAST];
    rmq_sel_t           sel_reg   [0:LAST];
    logic               rdy       [0:LAST];

    // Stage 0: signs, magnitudes, rounded numerators and the divisor
    logic [DW-1:0]      num_next [3];
    logic [2:0]         neg_next;
    logic [TERM_W-1:0]  mag;

    always_comb
    begin
        mag = '0;
        for (int l = 0; l < 3; l++)
        begin
            neg_next[l] = in_side.lane[l][TERM_W-1];
            mag         = neg_next[l] ? (TERM_W'(0) - in_side.lane[l]) : in_side.lane[l];
            num_next[l] = (DW'(mag) << FRAC_BITS) + (DW'(in_root) << 1);
        end
    end

    assign rdy[0] = !valid_reg[0] || rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (rdy[0])
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l]  <= num_next[l];
                quot_reg[0][l] <= '0;
            end
            neg_reg[0]  <= neg_next;
            den_reg[0]  <= DW'(in_root) << 2;
            root_reg[0] <= in_root;
            sel_reg[0]  <= in_side.sel;
        end
    end

    // Stages 1..QUOT_W: one quotient bit each, most significant first
    for (genvar k = 1; k <= LAST; k++) begin : g_step
        localparam int QB = QUOT_W - k;
        logic [DW-1:0]     dsh;
        logic [DW-1:0]     rem_next  [3];
        logic [QUOT_W-1:0] quot_next [3];

        always_comb
        begin
            dsh = den_reg[k-1] << QB;
            for (int l = 0; l < 3; l++)
            begin
                if (rem_reg[k-1][l] >= dsh)
                begin
                    rem_next[l]  = rem_reg[k-1][l] - dsh;
                    quot_next[l] = quot_reg[k-1][l] | (QUOT_W'(1) << QB);
                end
                else
                begin
                    rem_next[l]  = rem_reg[k-1][l];
                    quot_next[l] = quot_reg[k-1][l];
                end
            end
        end

        if (k == LAST) begin : g_rdy_last
            assign rdy[k] = !valid_reg[k] || out_ready;
        end
        else begin : g_rdy_mid
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (rdy[k])
                valid_reg[k] <= valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && valid_reg[k-1])
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[k][l]  <= rem_next[l];
                    quot_reg[k][l] <= quot_next[l];
                end
                neg_reg[k]  <= neg_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                root_reg[k] <= root_reg[k-1];
                sel_reg[k]  <= sel_reg[k-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[LAST];
    assign out_root  = root_reg[LAST];

    always_comb
    begin
        out_quot.sel = sel_reg[LAST];
        out_quot.neg = neg_reg[LAST];
        for (int l = 0; l < 3; l++)
            out_quot.quot[l] = quot_reg[LAST][l];
    end

endmodule

@@ rtl/core/rotation_matrix_to_quaternion_top.sv @@
`timescale 1ns / 1ps
// Pipeline: two front stages, R = ceil(rad_w(FRAC_BITS) / 2) root-bit stages,
//   the rounding stage of the root, 17 divider stages and the output register.
// Throughput: one matrix per cycle; every stage has its own valid bit and a
//   stage only holds when the one after it is full and stalled.
// Reset: clears the valid bits only; no other state.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Shepperd conversion of a fixed-point 3x3 rotation matrix to a quaternion,
// saturated to plus or minus one.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 (16 bits each, a00 lowest)
    input  logic [143:0]    s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    // qx, qy, qz, qw (16 bits each, qx lowest)
    output logic [63:0]     m_tdata
);

    localparam int S_W    = imax(BEST_W, FRAC_BITS) + 1;
    localparam int RAD_W  = rad_w(FRAC_BITS);
    localparam int ROOT_W = (RAD_W + 1) / 2 + 1;
    localparam int CMP_W  = imax(ROOT_W, DATA_W + 1);
    localparam logic [DATA_W:0] SAT_HI  = (FRAC_BITS < DATA_W - 1) ?
                                          (DATA_W + 1)'(1 << FRAC_BITS) :
                                          (DATA_W + 1)'(32767);
    localparam logic [DATA_W:0] SAT_NEG = (FRAC_BITS < DATA_W - 1) ?
                                          (DATA_W + 1)'(1 << FRAC_BITS) :
                                          (DATA_W + 1)'(32768);

    // Unpack the matrix elements
    logic signed [DATA_W-1:0] a [9];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            a[i] = s_tdata[i*DATA_W +: DATA_W];
    end

    // ------------------------------------------------------------------
    // Stage A: candidates and off-diagonal terms
    // ------------------------------------------------------------------
    logic                     va_reg;
    logic                     rdy_a;
    logic                     rdy_b;
    logic signed [CAND_W-1:0] cand_reg [4];
    logic signed [TERM_W-1:0] sxy_reg, szx_reg, syz_reg;
    logic signed [TERM_W-1:0] dx_reg, dy_reg, dz_reg;

    assign rdy_a    = !va_reg || rdy_b;
    assign s_tready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (rdy_a)
            va_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && s_tvalid)
        begin
            cand_reg[0] <= CAND_W'(a[0]) - CAND_W'(a[4]) - CAND_W'(a[8]);
            cand_reg[1] <= CAND_W'(a[4]) - CAND_W'(a[0]) - CAND_W'(a[8]);
            cand_reg[2] <= CAND_W'(a[8]) - CAND_W'(a[0]) - CAND_W'(a[4]);
            cand_reg[3] <= CAND_W'(a[0]) + CAND_W'(a[4]) + CAND_W'(a[8]);
            sxy_reg     <= TERM_W'(a[1]) + TERM_W'(a[3]);
            szx_reg     <= TERM_W'(a[6]) + TERM_W'(a[2]);
            syz_reg     <= TERM_W'(a[5]) + TERM_W'(a[7]);
            dx_reg      <= TERM_W'(a[5]) - TERM_W'(a[7]);
            dy_reg      <= TERM_W'(a[6]) - TERM_W'(a[2]);
            dz_reg      <= TERM_W'(a[1]) - TERM_W'(a[3]);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: pick the largest candidate (earliest wins a tie),
    // route the matching terms and form the radicand
    // ------------------------------------------------------------------
    logic                     vb_reg;
    logic                     sq_in_ready;
    logic [RAD_W-1:0]         rad_reg;
    rmq_side_t                side_reg;
    logic signed [CAND_W-1:0] best01, best23, best;
    rmq_sel_t                 sel01, sel23;
    rmq_side_t                side_next;
    logic [S_W-1:0]           s_sum;
    logic [RAD_W-1:0]         rad_next;

    always_comb
    begin
        best01 = cand_reg[0];
        sel01  = SEL_X;
        if (cand_reg[1] > cand_reg[0])
        begin
            best01 = cand_reg[1];
            sel01  = SEL_Y;
        end
        best23 = cand_reg[2];
        sel23  = SEL_Z;
        if (cand_reg[3] > cand_reg[2])
        begin
            best23 = cand_reg[3];
            sel23  = SEL_W;
        end
        best          = best01;
        side_next.sel = sel01;
        if (best23 > best01)
        begin
            best          = best23;
            side_next.sel = sel23;
        end

        // Lanes fill the output slots in order, skipping the root slot
        case (side_next.sel)
            SEL_X:
            begin
                side_next.lane[0] = sxy_reg;
                side_next.lane[1] = szx_reg;
                side_next.lane[2] = dx_reg;
            end
            SEL_Y:
            begin
                side_next.lane[0] = sxy_reg;
                side_next.lane[1] = syz_reg;
                side_next.lane[2] = dy_reg;
            end
            SEL_Z:
            begin
                side_next.lane[0] = szx_reg;
                side_next.lane[1] = syz_reg;
                side_next.lane[2] = dz_reg;
            end
            default:
            begin
                side_next.lane[0] = dx_reg;
                side_next.lane[1] = dy_reg;
                side_next.lane[2] = dz_reg;
            end
        endcase

        // Winner is never negative, so its low bits are its magnitude
        s_sum    = S_W'(best[BEST_W-1:0]) + (S_W'(1) << FRAC_BITS);
        rad_next = RAD_W'(s_sum) << (FRAC_BITS - 2);
    end

    assign rdy_b = !vb_reg || sq_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (rdy_b)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_b && va_reg)
        begin
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root and scaling
    // ------------------------------------------------------------------
    logic              sq_out_valid;
    logic              dv_in_ready;
    logic [ROOT_W-1:0] sq_root;
    rmq_side_t         sq_side;
    logic              dv_out_valid;
    logic              rdy_o;
    logic [ROOT_W-1:0] dv_root;
    rmq_quot_t         dv_quot;

    rmq_sqrt #(
        .RAD_W      (RAD_W)
    ) u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vb_reg),
        .in_ready   (sq_in_ready),
        .in_rad     (rad_reg),
        .in_side    (side_reg),
        .out_valid  (sq_out_valid),
        .out_ready  (dv_in_ready),
        .out_root   (sq_root),
        .out_side   (sq_side)
    );

    rmq_div #(
        .FRAC_BITS  (FRAC_BITS),
        .ROOT_W     (ROOT_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sq_out_valid),
        .in_ready   (dv_in_ready),
        .in_root    (sq_root),
        .in_side    (sq_side),
        .out_valid  (dv_out_valid),
        .out_ready  (rdy_o),
        .out_root   (dv_root),
        .out_quot   (dv_quot)
    );

    // ------------------------------------------------------------------
    // Output register: saturate, then place the root in its slot
    // ------------------------------------------------------------------
    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;
    logic [DATA_W-1:0]    lane_q [3];
    logic [DATA_W-1:0]    root_q;
    logic [CMP_W-1:0]     root_ext;
    logic [DATA_W:0]      mag_ext;
    logic [DATA_W:0]      neg_val;
    logic [63:0]          out_next;

    always_comb
    begin
        root_ext = CMP_W'(dv_root);
        if (root_ext > CMP_W'(SAT_HI))
            root_ext = CMP_W'(SAT_HI);
        root_q = root_ext[DATA_W-1:0];

        mag_ext = '0;
        neg_val = '0;
        for (int l = 0; l < 3; l++)
        begin
            mag_ext = {1'b0, dv_quot.quot[l]};
            if (dv_quot.neg[l])
            begin
                if (mag_ext > SAT_NEG)
                    mag_ext = SAT_NEG;
                neg_val   = (DATA_W + 1)'(0) - mag_ext;
                lane_q[l] = neg_val[DATA_W-1:0];
            end
            else
            begin
                if (mag_ext > SAT_HI)
                    mag_ext = SAT_HI;
                lane_q[l] = mag_ext[DATA_W-1:0];
            end
        end

        case (dv_quot.sel)
            SEL_X:   out_next = {lane_q[2], lane_q[1], lane_q[0], root_q};
            SEL_Y:   out_next = {lane_q[2], lane_q[1], root_q, lane_q[0]};
            SEL_Z:   out_next = {lane_q[2], root_q, lane_q[1], lane_q[0]};
            default: out_next = {root_q, lane_q[2], lane_q[1], lane_q[0]};
        endcase
    end

    assign rdy_o = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rdy_o)
            out_valid_reg <= dv_out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_o && dv_out_valid)
            out_data_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
